// ===== design/cam_pkg.sv =====
`default_nettype none

package cam_pkg;

    typedef struct packed {
        logic        opcode;
        logic [63:0] block_high;
        logic [63:0] block_low;
    } t_in_item;

    typedef struct packed {
        logic [63:0] out_high;
        logic [63:0] out_low;
    } t_out_item;

    typedef enum logic [2:0] {
        REG_KEY_WORD_0    = 3'd0,
        REG_KEY_WORD_1    = 3'd1,
        REG_KEY_WORD_2    = 3'd2,
        REG_KEY_WORD_3    = 3'd3,
        REG_LONG_KEY_MODE = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        KS_LOAD,
        KS_RUN,
        KS_DONE
    } t_ks_state;

    // whitening, round and fl subkeys
    typedef struct packed {
        logic [3:0][63:0]  kw;
        logic [23:0][63:0] k;
        logic [5:0][63:0]  ke;
    } t_subkeys;

    typedef struct packed {
        logic     ready;
        logic     lng;
        t_subkeys sk;
    } t_ks_status;

    typedef struct packed {
        logic        dec;
        logic [63:0] d1;
        logic [63:0] d2;
    } t_pipe;

    localparam logic [7:0] SBOX1 [256] = '{
        8'h70,8'h82,8'h2c,8'hec,8'hb3,8'h27,8'hc0,8'he5,
        8'he4,8'h85,8'h57,8'h35,8'hea,8'h0c,8'hae,8'h41,
        8'h23,8'hef,8'h6b,8'h93,8'h45,8'h19,8'ha5,8'h21,
        8'hed,8'h0e,8'h4f,8'h4e,8'h1d,8'h65,8'h92,8'hbd,
        8'h86,8'hb8,8'haf,8'h8f,8'h7c,8'heb,8'h1f,8'hce,
        8'h3e,8'h30,8'hdc,8'h5f,8'h5e,8'hc5,8'h0b,8'h1a,
        8'ha6,8'he1,8'h39,8'hca,8'hd5,8'h47,8'h5d,8'h3d,
        8'hd9,8'h01,8'h5a,8'hd6,8'h51,8'h56,8'h6c,8'h4d,
        8'h8b,8'h0d,8'h9a,8'h66,8'hfb,8'hcc,8'hb0,8'h2d,
        8'h74,8'h12,8'h2b,8'h20,8'hf0,8'hb1,8'h84,8'h99,
        8'hdf,8'h4c,8'hcb,8'hc2,8'h34,8'h7e,8'h76,8'h05,
        8'h6d,8'hb7,8'ha9,8'h31,8'hd1,8'h17,8'h04,8'hd7,
        8'h14,8'h58,8'h3a,8'h61,8'hde,8'h1b,8'h11,8'h1c,
        8'h32,8'h0f,8'h9c,8'h16,8'h53,8'h18,8'hf2,8'h22,
        8'hfe,8'h44,8'hcf,8'hb2,8'hc3,8'hb5,8'h7a,8'h91,
        8'h24,8'h08,8'he8,8'ha8,8'h60,8'hfc,8'h69,8'h50,
        8'haa,8'hd0,8'ha0,8'h7d,8'ha1,8'h89,8'h62,8'h97,
        8'h54,8'h5b,8'h1e,8'h95,8'he0,8'hff,8'h64,8'hd2,
        8'h10,8'hc4,8'h00,8'h48,8'ha3,8'hf7,8'h75,8'hdb,
        8'h8a,8'h03,8'he6,8'hda,8'h09,8'h3f,8'hdd,8'h94,
        8'h87,8'h5c,8'h83,8'h02,8'hcd,8'h4a,8'h90,8'h33,
        8'h73,8'h67,8'hf6,8'hf3,8'h9d,8'h7f,8'hbf,8'he2,
        8'h52,8'h9b,8'hd8,8'h26,8'hc8,8'h37,8'hc6,8'h3b,
        8'h81,8'h96,8'h6f,8'h4b,8'h13,8'hbe,8'h63,8'h2e,
        8'he9,8'h79,8'ha7,8'h8c,8'h9f,8'h6e,8'hbc,8'h8e,
        8'h29,8'hf5,8'hf9,8'hb6,8'h2f,8'hfd,8'hb4,8'h59,
        8'h78,8'h98,8'h06,8'h6a,8'he7,8'h46,8'h71,8'hba,
        8'hd4,8'h25,8'hab,8'h42,8'h88,8'ha2,8'h8d,8'hfa,
        8'h72,8'h07,8'hb9,8'h55,8'hf8,8'hee,8'hac,8'h0a,
        8'h36,8'h49,8'h2a,8'h68,8'h3c,8'h38,8'hf1,8'ha4,
        8'h40,8'h28,8'hd3,8'h7b,8'hbb,8'hc9,8'h43,8'hc1,
        8'h15,8'he3,8'had,8'hf4,8'h77,8'hc7,8'h80,8'h9e
    };

    function automatic logic [63:0] sigma(input logic [2:0] idx);
        logic [63:0] s;
        case (idx)
            3'd0:    s = 64'ha09e667f3bcc908b;
            3'd1:    s = 64'hb67ae8584caa73b2;
            3'd2:    s = 64'hc6ef372fe94f82be;
            3'd3:    s = 64'h54ff53a5f1d36f1c;
            3'd4:    s = 64'h10e527fade682d1d;
            3'd5:    s = 64'hb05688c2b3e6c1fd;
            default: s = 64'h0;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] rl8(input logic [7:0] v);
        return {v[6:0], v[7]};
    endfunction

    function automatic logic [7:0] rr8(input logic [7:0] v);
        return {v[0], v[7:1]};
    endfunction

    function automatic logic [63:0] f_func(input logic [63:0] x, input logic [63:0] k);
        logic [63:0] t;
        logic [7:0]  y1, y2, y3, y4, y5, y6, y7, y8;
        logic [7:0]  z1, z2, z3, z4, z5, z6, z7, z8;
        t  = x ^ k;
        y1 = SBOX1[t[63:56]];
        y2 = rl8(SBOX1[t[55:48]]);
        y3 = rr8(SBOX1[t[47:40]]);
        y4 = SBOX1[rl8(t[39:32])];
        y5 = rl8(SBOX1[t[31:24]]);
        y6 = rr8(SBOX1[t[23:16]]);
        y7 = SBOX1[rl8(t[15:8])];
        y8 = SBOX1[t[7:0]];
        z1 = y1 ^ y3 ^ y4 ^ y6 ^ y7 ^ y8;
        z2 = y1 ^ y2 ^ y4 ^ y5 ^ y7 ^ y8;
        z3 = y1 ^ y2 ^ y3 ^ y5 ^ y6 ^ y8;
        z4 = y2 ^ y3 ^ y4 ^ y5 ^ y6 ^ y7;
        z5 = y1 ^ y2 ^ y6 ^ y7 ^ y8;
        z6 = y2 ^ y3 ^ y5 ^ y7 ^ y8;
        z7 = y3 ^ y4 ^ y5 ^ y6 ^ y8;
        z8 = y1 ^ y4 ^ y5 ^ y6 ^ y7;
        return {z1, z2, z3, z4, z5, z6, z7, z8};
    endfunction

    function automatic logic [31:0] rl32(input logic [31:0] v);
        return {v[30:0], v[31]};
    endfunction

    function automatic logic [63:0] fl_fwd(input logic [63:0] x, input logic [63:0] k);
        logic [31:0] xl, xr;
        xl = x[63:32];
        xr = x[31:0];
        xr = xr ^ rl32(xl & k[63:32]);
        xl = xl ^ (xr | k[31:0]);
        return {xl, xr};
    endfunction

    function automatic logic [63:0] fl_inv(input logic [63:0] y, input logic [63:0] k);
        logic [31:0] yl, yr;
        yl = y[63:32];
        yr = y[31:0];
        yl = yl ^ (yr | k[31:0]);
        yr = yr ^ rl32(yl & k[63:32]);
        return {yl, yr};
    endfunction

    // fixed rotation only, so this is wiring
    function automatic logic [127:0] rot128(input logic [127:0] v, input int unsigned n);
        logic [255:0] w;
        w = {v, v} << n;
        return w[255:128];
    endfunction

endpackage

`default_nettype wire

// ===== design/camellia_block_cipher.sv =====
`default_nettype none

// channel  | valid       | stall       | payload
// ---------+-------------+-------------+---------------------------
// input    | i_in_valid  | o_in_stall  | i_in_data  (t_in_item)
// output   | o_out_valid | i_out_stall | o_out_data (t_out_item)
// config   | i_cfg_we    | -           | i_cfg_index, i_cfg_wdata
//
// 29 register stages: input whitening, one stage per feistel round, one per fl
// layer, output whitening; one block per cycle sustained while nothing stalls.
// in 128-bit mode the last fl layer and rounds 19..24 pass the data through.
// after reset and after each key write the key schedule steps through its
// feistel rounds on its single f unit; the input is stalled meanwhile.
// a stall lets each stage fill its bubble; a full stage holds until taken.

module camellia_block_cipher (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [63:0]        i_cfg_wdata,
    input  wire logic               i_in_valid,
    output      logic               o_in_stall,
    input  wire cam_pkg::t_in_item  i_in_data,
    output      logic               o_out_valid,
    input  wire logic               i_out_stall,
    output      cam_pkg::t_out_item o_out_data
);

    localparam int N_STAGES = 29;

    cam_pkg::t_ks_status w_ks;
    cam_pkg::t_pipe      r_st [N_STAGES];
    cam_pkg::t_pipe      n_st [N_STAGES];
    logic [N_STAGES-1:0] r_v;
    logic [N_STAGES-1:0] w_free;
    logic                w_in_acc;

    cam_keysched u_ks (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_status    (w_ks)
    );

    assign o_in_stall = !w_free[0] || !w_ks.ready;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    assign w_free[N_STAGES-1] = !r_v[N_STAGES-1] || !i_out_stall;

    genvar s;
    generate
        for (s = 0; s < N_STAGES - 1; s++) begin : g_free
            assign w_free[s] = !r_v[s] || w_free[s+1];
        end

        for (s = 0; s < N_STAGES; s++) begin : g_stage
            if (s == 0) begin : g_win
                always_comb begin
                    n_st[s].dec = i_in_data.opcode;
                    n_st[s].d1  = i_in_data.block_high ^
                                  (i_in_data.opcode ? w_ks.sk.kw[2] : w_ks.sk.kw[0]);
                    n_st[s].d2  = i_in_data.block_low ^
                                  (i_in_data.opcode ? w_ks.sk.kw[3] : w_ks.sk.kw[1]);
                end
            end else if (s == N_STAGES - 1) begin : g_wout
                // final swap of the halves
                always_comb begin
                    n_st[s].dec = r_st[s-1].dec;
                    n_st[s].d1  = r_st[s-1].d2 ^
                                  (r_st[s-1].dec ? w_ks.sk.kw[0] : w_ks.sk.kw[2]);
                    n_st[s].d2  = r_st[s-1].d1 ^
                                  (r_st[s-1].dec ? w_ks.sk.kw[1] : w_ks.sk.kw[3]);
                end
            end else begin : g_mid
                localparam int POS = s - 1;
                localparam int GRP = POS / 7;
                localparam int OFF = POS % 7;
                if (OFF == 6) begin : g_fl
                    localparam int JS = (GRP < 2) ? (1 - GRP) : 0;
                    localparam int JL = 2 - GRP;
                    logic [63:0] w_fa, w_fb;
                    logic        w_act;
                    assign w_act = (GRP < 2) || w_ks.lng;
                    always_comb begin
                        if (!r_st[s-1].dec) begin
                            w_fa = w_ks.sk.ke[2*GRP];
                            w_fb = w_ks.sk.ke[2*GRP+1];
                        end else if (w_ks.lng) begin
                            w_fa = w_ks.sk.ke[2*JL+1];
                            w_fb = w_ks.sk.ke[2*JL];
                        end else begin
                            w_fa = w_ks.sk.ke[2*JS+1];
                            w_fb = w_ks.sk.ke[2*JS];
                        end
                        n_st[s] = r_st[s-1];
                        if (w_act) begin
                            n_st[s].d1 = cam_pkg::fl_fwd(r_st[s-1].d1, w_fa);
                            n_st[s].d2 = cam_pkg::fl_inv(r_st[s-1].d2, w_fb);
                        end
                    end
                end else begin : g_rnd
                    localparam int RI = GRP * 6 + OFF;
                    localparam int KS = (RI < 18) ? (17 - RI) : 0;
                    localparam int KL = 23 - RI;
                    logic [63:0] w_k, w_f;
                    logic        w_act;
                    assign w_act = (RI < 18) || w_ks.lng;
                    always_comb begin
                        if (!r_st[s-1].dec) w_k = w_ks.sk.k[RI];
                        else if (w_ks.lng)  w_k = w_ks.sk.k[KL];
                        else                w_k = w_ks.sk.k[KS];
                        n_st[s] = r_st[s-1];
                        if (RI % 2 == 0) begin
                            w_f = cam_pkg::f_func(r_st[s-1].d1, w_k);
                            if (w_act) n_st[s].d2 = r_st[s-1].d2 ^ w_f;
                        end else begin
                            w_f = cam_pkg::f_func(r_st[s-1].d2, w_k);
                            if (w_act) n_st[s].d1 = r_st[s-1].d1 ^ w_f;
                        end
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_free[s]) r_st[s] <= n_st[s];
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[s] <= 1'b0;
                end else if (w_free[s]) begin
                    r_v[s] <= (s == 0) ? w_in_acc : r_v[(s == 0) ? 0 : s - 1];
                end
            end
        end
    endgenerate

    assign o_out_valid         = r_v[N_STAGES-1];
    assign o_out_data.out_high = r_st[N_STAGES-1].d1;
    assign o_out_data.out_low  = r_st[N_STAGES-1].d2;

    // a key write restarts the schedule, which must hold off new blocks
    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && i_cfg_index == cam_pkg::REG_KEY_WORD_0) |=> !w_ks.ready)
        else $error("key write did not restart the key schedule");

    a_no_accept_unkeyed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_ks.ready |-> !w_in_acc)
        else $error("block accepted before subkeys were ready");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_v[0])
        else $error("accepted block lost at the first stage");

    a_full_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[N_STAGES-2] && !w_free[N_STAGES-2]) |=> r_v[N_STAGES-2])
        else $error("stalled stage dropped its block");

endmodule

`default_nettype wire

// ===== design/cam_keysched.sv =====
`default_nettype none

module cam_keysched (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [2:0]            i_cfg_index,
    input  wire logic [63:0]           i_cfg_wdata,
    output cam_pkg::t_ks_status        o_status
);

    logic [63:0] r_key0, r_key1, r_key2, r_key3;
    logic        r_lng;
    logic [63:0] r_d1, r_d2, n_d1, n_d2;
    logic [127:0] r_ka, r_kb;
    logic [2:0]  r_step;
    logic        w_wr_hit;
    logic        w_ka_we, w_kb_we;
    logic [63:0] w_kr0, w_kr1, w_fx, w_fo;
    logic [127:0] w_kl, w_kr;
    cam_pkg::t_ks_state r_state, n_state;
    cam_pkg::t_subkeys  w_sk;

    always_comb begin
        case (i_cfg_index)
            cam_pkg::REG_KEY_WORD_0, cam_pkg::REG_KEY_WORD_1, cam_pkg::REG_KEY_WORD_2,
            cam_pkg::REG_KEY_WORD_3, cam_pkg::REG_LONG_KEY_MODE: w_wr_hit = i_cfg_we;
            default: w_wr_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0;
            r_key1 <= '0;
            r_key2 <= '0;
            r_key3 <= '0;
            r_lng  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cam_pkg::REG_KEY_WORD_0:    r_key0 <= i_cfg_wdata;
                cam_pkg::REG_KEY_WORD_1:    r_key1 <= i_cfg_wdata;
                cam_pkg::REG_KEY_WORD_2:    r_key2 <= i_cfg_wdata;
                cam_pkg::REG_KEY_WORD_3:    r_key3 <= i_cfg_wdata;
                cam_pkg::REG_LONG_KEY_MODE: r_lng  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign w_kr0 = r_lng ? r_key2 : 64'h0;
    assign w_kr1 = r_lng ? r_key3 : 64'h0;
    assign w_kl  = {r_key0, r_key1};
    assign w_kr  = {w_kr0, w_kr1};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            cam_pkg::KS_LOAD: n_state = cam_pkg::KS_RUN;
            cam_pkg::KS_RUN:  if (r_step == 3'd5) n_state = cam_pkg::KS_DONE;
            cam_pkg::KS_DONE: n_state = cam_pkg::KS_DONE;
            default:          n_state = cam_pkg::KS_LOAD;
        endcase
        if (w_wr_hit) n_state = cam_pkg::KS_LOAD;
    end

    // one shared f unit, one feistel step a cycle
    assign w_fx = r_step[0] ? r_d2 : r_d1;
    assign w_fo = cam_pkg::f_func(w_fx, cam_pkg::sigma(r_step));

    always_comb begin
        n_d1    = r_d1;
        n_d2    = r_d2;
        w_ka_we = 1'b0;
        w_kb_we = 1'b0;
        case (r_state)
            cam_pkg::KS_LOAD: begin
                n_d1 = r_key0 ^ w_kr0;
                n_d2 = r_key1 ^ w_kr1;
            end
            cam_pkg::KS_RUN: begin
                case (r_step)
                    3'd1: begin
                        n_d1 = r_d1 ^ w_fo ^ r_key0;
                        n_d2 = r_d2 ^ r_key1;
                    end
                    3'd3: begin
                        // ka done, seed the kb rounds
                        w_ka_we = 1'b1;
                        n_d1    = r_d1 ^ w_fo ^ w_kr0;
                        n_d2    = r_d2 ^ w_kr1;
                    end
                    3'd5: w_kb_we = 1'b1;
                    default: n_d2 = r_d2 ^ w_fo;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cam_pkg::KS_LOAD;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= (r_state == cam_pkg::KS_RUN) ? r_step + 3'd1 : 3'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d1 <= n_d1;
        r_d2 <= n_d2;
        if (w_ka_we) r_ka <= {r_d1 ^ w_fo, r_d2};
        if (w_kb_we) r_kb <= {r_d1 ^ w_fo, r_d2};
    end

    always_comb begin
        logic [127:0] t;
        t    = '0;
        w_sk = '0;
        w_sk.kw[0] = r_key0;
        w_sk.kw[1] = r_key1;
        if (!r_lng) begin
            {w_sk.k[0],  w_sk.k[1]}  = r_ka;
            {w_sk.k[2],  w_sk.k[3]}  = cam_pkg::rot128(w_kl, 15);
            {w_sk.k[4],  w_sk.k[5]}  = cam_pkg::rot128(r_ka, 15);
            {w_sk.ke[0], w_sk.ke[1]} = cam_pkg::rot128(r_ka, 30);
            {w_sk.k[6],  w_sk.k[7]}  = cam_pkg::rot128(w_kl, 45);
            t = cam_pkg::rot128(r_ka, 45);
            w_sk.k[8] = t[127:64];
            t = cam_pkg::rot128(w_kl, 60);
            w_sk.k[9] = t[63:0];
            {w_sk.k[10], w_sk.k[11]} = cam_pkg::rot128(r_ka, 60);
            {w_sk.ke[2], w_sk.ke[3]} = cam_pkg::rot128(w_kl, 77);
            {w_sk.k[12], w_sk.k[13]} = cam_pkg::rot128(w_kl, 94);
            {w_sk.k[14], w_sk.k[15]} = cam_pkg::rot128(r_ka, 94);
            {w_sk.k[16], w_sk.k[17]} = cam_pkg::rot128(w_kl, 111);
            {w_sk.kw[2], w_sk.kw[3]} = cam_pkg::rot128(r_ka, 111);
        end else begin
            {w_sk.k[0],  w_sk.k[1]}  = r_kb;
            {w_sk.k[2],  w_sk.k[3]}  = cam_pkg::rot128(w_kr, 15);
            {w_sk.k[4],  w_sk.k[5]}  = cam_pkg::rot128(r_ka, 15);
            {w_sk.ke[0], w_sk.ke[1]} = cam_pkg::rot128(w_kr, 30);
            {w_sk.k[6],  w_sk.k[7]}  = cam_pkg::rot128(r_kb, 30);
            {w_sk.k[8],  w_sk.k[9]}  = cam_pkg::rot128(w_kl, 45);
            {w_sk.k[10], w_sk.k[11]} = cam_pkg::rot128(r_ka, 45);
            {w_sk.ke[2], w_sk.ke[3]} = cam_pkg::rot128(w_kl, 60);
            {w_sk.k[12], w_sk.k[13]} = cam_pkg::rot128(w_kr, 60);
            {w_sk.k[14], w_sk.k[15]} = cam_pkg::rot128(r_kb, 60);
            {w_sk.k[16], w_sk.k[17]} = cam_pkg::rot128(w_kl, 77);
            {w_sk.ke[4], w_sk.ke[5]} = cam_pkg::rot128(r_ka, 77);
            {w_sk.k[18], w_sk.k[19]} = cam_pkg::rot128(w_kr, 94);
            {w_sk.k[20], w_sk.k[21]} = cam_pkg::rot128(r_ka, 94);
            {w_sk.k[22], w_sk.k[23]} = cam_pkg::rot128(w_kl, 111);
            {w_sk.kw[2], w_sk.kw[3]} = cam_pkg::rot128(r_kb, 111);
        end
    end

    // outputs
    always_comb begin
        o_status.ready = (r_state == cam_pkg::KS_DONE);
        o_status.lng   = r_lng;
        o_status.sk    = w_sk;
    end

endmodule

`default_nettype wire

// ===== tb/camellia_block_cipher_test.sv =====
`timescale 1ns / 1ps

module camellia_block_cipher_test;

    localparam int          CYCLE_LIMIT   = 600000;
    localparam int          PIPE_DEPTH    = 29;
    localparam logic [2:0]  REG_NONE_LOW  = 3'd5;
    localparam logic [2:0]  REG_NONE_HIGH = 3'd7;
    localparam logic        OP_ENCRYPT    = 1'b0;
    localparam logic        OP_DECRYPT    = 1'b1;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [2:0] i_cfg_index = 3'd0;
    logic [63:0] i_cfg_wdata = 64'd0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    cam_pkg::t_in_item   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    cam_pkg::t_out_item  o_out_data;

    camellia_block_cipher u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // cipher state held by the testbench
    logic [63:0] key_words [4];
    logic        long_key;
    logic [63:0] subkeys [34];
    cam_pkg::t_out_item pending_blocks [$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          idle_enable = 1'b1;

    function automatic logic [7:0] rol8(input logic [7:0] b);
        return {b[6:0], b[7]};
    endfunction

    function automatic logic [7:0] ror8(input logic [7:0] b);
        return {b[0], b[7:1]};
    endfunction

    function automatic logic [31:0] rol32(input logic [31:0] w);
        return {w[30:0], w[31]};
    endfunction

    function automatic logic [63:0] round_mix(input logic [63:0] x, input logic [63:0] k);
        logic [63:0] t;
        logic [7:0]  s [8];
        t    = x ^ k;
        s[0] = cam_pkg::SBOX1[t[63:56]];
        s[1] = rol8(cam_pkg::SBOX1[t[55:48]]);
        s[2] = ror8(cam_pkg::SBOX1[t[47:40]]);
        s[3] = cam_pkg::SBOX1[rol8(t[39:32])];
        s[4] = rol8(cam_pkg::SBOX1[t[31:24]]);
        s[5] = ror8(cam_pkg::SBOX1[t[23:16]]);
        s[6] = cam_pkg::SBOX1[rol8(t[15:8])];
        s[7] = cam_pkg::SBOX1[t[7:0]];
        return {s[0] ^ s[2] ^ s[3] ^ s[5] ^ s[6] ^ s[7],
                s[0] ^ s[1] ^ s[3] ^ s[4] ^ s[6] ^ s[7],
                s[0] ^ s[1] ^ s[2] ^ s[4] ^ s[5] ^ s[7],
                s[1] ^ s[2] ^ s[3] ^ s[4] ^ s[5] ^ s[6],
                s[0] ^ s[1] ^ s[5] ^ s[6] ^ s[7],
                s[1] ^ s[2] ^ s[4] ^ s[6] ^ s[7],
                s[2] ^ s[3] ^ s[4] ^ s[5] ^ s[7],
                s[0] ^ s[3] ^ s[4] ^ s[5] ^ s[6]};
    endfunction

    function automatic logic [63:0] fl_apply(input logic [63:0] x, input logic [63:0] k);
        logic [31:0] l, r;
        l = x[63:32];
        r = x[31:0] ^ rol32(x[63:32] & k[63:32]);
        l = l ^ (r | k[31:0]);
        return {l, r};
    endfunction

    function automatic logic [63:0] fl_undo(input logic [63:0] y, input logic [63:0] k);
        logic [31:0] l, r;
        l = y[63:32] ^ (y[31:0] | k[31:0]);
        r = y[31:0] ^ rol32(l & k[63:32]);
        return {l, r};
    endfunction

    function automatic logic [127:0] rotl128(input logic [127:0] v, input int n);
        if (n == 0) return v;
        return (v << n) | (v >> (128 - n));
    endfunction

    task automatic put_pair(input int idx, input logic [127:0] v, input int n);
        logic [127:0] w;
        w = rotl128(v, n);
        subkeys[idx]     = w[127:64];
        subkeys[idx + 1] = w[63:0];
    endtask

    task automatic expand_schedule();
        logic [127:0] kl, kr, ka, kb, w;
        logic [63:0]  d1, d2;
        kl = {key_words[0], key_words[1]};
        kr = long_key ? {key_words[2], key_words[3]} : 128'd0;
        d1 = kl[127:64] ^ kr[127:64];
        d2 = kl[63:0] ^ kr[63:0];
        d2 ^= round_mix(d1, 64'ha09e667f3bcc908b);
        d1 ^= round_mix(d2, 64'hb67ae8584caa73b2);
        d1 ^= kl[127:64];
        d2 ^= kl[63:0];
        d2 ^= round_mix(d1, 64'hc6ef372fe94f82be);
        d1 ^= round_mix(d2, 64'h54ff53a5f1d36f1c);
        ka = {d1, d2};
        foreach (subkeys[i]) subkeys[i] = 64'd0;
        put_pair(0, kl, 0);
        if (!long_key) begin
            put_pair(4, ka, 0);
            put_pair(6, kl, 15);
            put_pair(8, ka, 15);
            put_pair(28, ka, 30);
            put_pair(10, kl, 45);
            w = rotl128(ka, 45);
            subkeys[12] = w[127:64];
            w = rotl128(kl, 60);
            subkeys[13] = w[63:0];
            put_pair(14, ka, 60);
            put_pair(30, kl, 77);
            put_pair(16, kl, 94);
            put_pair(18, ka, 94);
            put_pair(20, kl, 111);
            put_pair(2, ka, 111);
        end else begin
            d1 = ka[127:64] ^ kr[127:64];
            d2 = ka[63:0] ^ kr[63:0];
            d2 ^= round_mix(d1, 64'h10e527fade682d1d);
            d1 ^= round_mix(d2, 64'hb05688c2b3e6c1fd);
            kb = {d1, d2};
            put_pair(4, kb, 0);
            put_pair(6, kr, 15);
            put_pair(8, ka, 15);
            put_pair(28, kr, 30);
            put_pair(10, kb, 30);
            put_pair(12, kl, 45);
            put_pair(14, ka, 45);
            put_pair(30, kl, 60);
            put_pair(16, kr, 60);
            put_pair(18, kb, 60);
            put_pair(20, kl, 77);
            put_pair(32, ka, 77);
            put_pair(22, kr, 94);
            put_pair(24, ka, 94);
            put_pair(26, kl, 111);
            put_pair(2, kb, 111);
        end
    endtask

    function automatic cam_pkg::t_out_item cipher_block(input cam_pkg::t_in_item blk);
        int          rounds, groups, j, a, b, i;
        logic        dec;
        logic [63:0] d1, d2, fa, fb;
        cam_pkg::t_out_item res;
        dec    = blk.opcode == OP_DECRYPT;
        rounds = long_key ? 24 : 18;
        groups = rounds / 6;
        d1 = blk.block_high ^ (dec ? subkeys[2] : subkeys[0]);
        d2 = blk.block_low ^ (dec ? subkeys[3] : subkeys[1]);
        for (int g = 0; g < groups; g++) begin
            if (g > 0) begin
                j  = dec ? groups - 1 - g : g - 1;
                fa = subkeys[28 + 2 * j + (dec ? 1 : 0)];
                fb = subkeys[28 + 2 * j + (dec ? 0 : 1)];
                d1 = fl_apply(d1, fa);
                d2 = fl_undo(d2, fb);
            end
            for (int r = 0; r < 6; r += 2) begin
                i  = g * 6 + r;
                a  = dec ? rounds - 1 - i : i;
                b  = dec ? rounds - 2 - i : i + 1;
                d2 ^= round_mix(d1, subkeys[4 + a]);
                d1 ^= round_mix(d2, subkeys[4 + b]);
            end
        end
        res.out_high = d2 ^ (dec ? subkeys[0] : subkeys[2]);
        res.out_low  = d1 ^ (dec ? subkeys[1] : subkeys[3]);
        return res;
    endfunction

    // caller sits on a rising edge; write enable is left high for back-to-back writes
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx <= cam_pkg::REG_LONG_KEY_MODE) begin
            if (idx == cam_pkg::REG_LONG_KEY_MODE) long_key = val[0];
            else key_words[idx[1:0]] = val;
            expand_schedule();
        end
    endtask

    task automatic send_block(input cam_pkg::t_in_item blk, input bit known,
                              input cam_pkg::t_out_item ref_out);
        i_in_valid <= 1'b1;
        i_in_data  <= blk;
        forever begin
            @(negedge i_clk);
            if (!o_in_stall) break;
        end
        @(posedge i_clk);
        pending_blocks.push_back(known ? ref_out : cipher_block(blk));
    endtask

    task automatic drain_pipe();
        i_in_valid <= 1'b0;
        while (pending_blocks.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 64'd0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // result checking
    always @(posedge i_clk) begin
        cam_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_blocks.size() == 0) begin
                $error("unexpected transfer out: %h", o_out_data);
                error_count++;
            end else begin
                want = pending_blocks.pop_front();
                if (o_out_data.out_high !== want.out_high) begin
                    $error("out_high expected %h actual %h", want.out_high,
                           o_out_data.out_high);
                    error_count++;
                end
                if (o_out_data.out_low !== want.out_low) begin
                    $error("out_low expected %h actual %h", want.out_low,
                           o_out_data.out_low);
                    error_count++;
                end
            end
        end
    end

    // receiver back-pressure in bursts
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            n = $urandom_range(1, 40);
            repeat (n) @(posedge i_clk);
            if (idle_enable && $urandom_range(0, 2) != 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    typedef struct {
        bit          is_write;
        logic [2:0]  idx;
        logic        op;
        logic [63:0] hi;
        logic [63:0] lo;
        bit          known;
        logic [63:0] want_hi;
        logic [63:0] want_lo;
    } t_step_row;

    localparam logic [63:0] ONES = 64'hffffffffffffffff;

    t_step_row directed [] = '{
        // block before any key write: schedule from all-zero key
        '{0, 0, OP_ENCRYPT, 64'd0, 64'd0, 0, 0, 0},
        '{0, 0, OP_DECRYPT, ONES, ONES, 0, 0, 0},
        '{0, 0, OP_ENCRYPT, ONES, 64'd0, 0, 0, 0},
        '{1, cam_pkg::REG_KEY_WORD_0, 0, 64'h0123456789abcdef, 0, 0, 0, 0},
        '{1, cam_pkg::REG_KEY_WORD_1, 0, 64'hfedcba9876543210, 0, 0, 0, 0},
        '{0, 0, OP_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210, 1,
          64'h6767313854966973, 64'h0857065648eabe43},
        '{0, 0, OP_DECRYPT, 64'h6767313854966973, 64'h0857065648eabe43, 1,
          64'h0123456789abcdef, 64'hfedcba9876543210},
        // out-of-range index must leave the key alone
        '{1, REG_NONE_HIGH, 0, ONES, 0, 0, 0, 0},
        '{1, REG_NONE_LOW, 0, 64'd0, 0, 0, 0, 0},
        '{0, 0, OP_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210, 1,
          64'h6767313854966973, 64'h0857065648eabe43},
        '{1, cam_pkg::REG_KEY_WORD_2, 0, 64'h0011223344556677, 0, 0, 0, 0},
        '{1, cam_pkg::REG_KEY_WORD_3, 0, 64'h8899aabbccddeeff, 0, 0, 0, 0},
        '{1, cam_pkg::REG_LONG_KEY_MODE, 0, 64'd1, 0, 0, 0, 0},
        '{0, 0, OP_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210, 1,
          64'h9acc237dff16d76c, 64'h20ef7c919e3a7509},
        '{0, 0, OP_DECRYPT, 64'h9acc237dff16d76c, 64'h20ef7c919e3a7509, 1,
          64'h0123456789abcdef, 64'hfedcba9876543210},
        '{1, cam_pkg::REG_KEY_WORD_0, 0, ONES, 0, 0, 0, 0},
        '{1, cam_pkg::REG_KEY_WORD_1, 0, ONES, 0, 0, 0, 0},
        '{1, cam_pkg::REG_KEY_WORD_2, 0, ONES, 0, 0, 0, 0},
        '{1, cam_pkg::REG_KEY_WORD_3, 0, ONES, 0, 0, 0, 0},
        '{0, 0, OP_ENCRYPT, ONES, ONES, 0, 0, 0},
        '{0, 0, OP_DECRYPT, 64'd0, 64'd0, 0, 0, 0},
        '{1, cam_pkg::REG_LONG_KEY_MODE, 0, 64'hfffffffffffffffe, 0, 0, 0, 0},
        '{0, 0, OP_ENCRYPT, ONES, ONES, 0, 0, 0},
        '{0, 0, OP_DECRYPT, 64'd0, ONES, 0, 0, 0}
    };

    initial begin
        cam_pkg::t_in_item  blk;
        cam_pkg::t_out_item typed;
        bit        writing;
        int        burst;
        int        phase_len;

        foreach (key_words[i]) key_words[i] = 64'd0;
        long_key = 1'b0;
        expand_schedule();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        writing = 1'b0;
        foreach (directed[r]) begin
            if (directed[r].is_write) begin
                if (!writing) drain_pipe();
                writing = 1'b1;
                write_reg(directed[r].idx, directed[r].hi);
            end else begin
                if (writing) i_cfg_we <= 1'b0;
                writing = 1'b0;
                blk   = '{opcode: directed[r].op, block_high: directed[r].hi,
                          block_low: directed[r].lo};
                typed = '{out_high: directed[r].want_hi, out_low: directed[r].want_lo};
                send_block(blk, directed[r].known, typed);
            end
        end

        // random phases, each after random key register writes (all of them in the first two)
        for (int phase = 0; phase < 10; phase++) begin
            drain_pipe();
            for (int k = 0; k <= cam_pkg::REG_LONG_KEY_MODE; k++) begin
                if (phase < 2 || $urandom_range(0, 2) != 0) begin
                    if (k == cam_pkg::REG_LONG_KEY_MODE)
                        write_reg(cam_pkg::t_reg_idx'(k),
                                  {$urandom, $urandom_range(0, 1) == 1 ?
                                  32'hffffffff : 32'h0} ^ 64'(phase % 2));
                    else
                        write_reg(k[2:0], phase == 0 ? ONES : rand_word());
                end
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(3'($urandom_range(REG_NONE_LOW, REG_NONE_HIGH)), rand_word());
            i_cfg_we <= 1'b0;
            if (phase == 9) idle_enable = 1'b0;
            phase_len = 140;
            for (int n = 0; n < phase_len; n++) begin
                if (idle_enable && $urandom_range(0, 9) == 0) begin
                    burst = $urandom_range(1, 18);
                    i_in_valid <= 1'b0;
                    repeat (burst) @(posedge i_clk);
                end
                blk.opcode     = 1'($urandom_range(0, 1));
                blk.block_high = rand_word();
                blk.block_low  = rand_word();
                send_block(blk, 1'b0, '0);
            end
        end

        drain_pipe();
        repeat (PIPE_DEPTH + 8) @(posedge i_clk);
        if (error_count == 0 && pending_blocks.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
